[src/assert_macros.svh]
// Assertion macros used by the core RTL file of the LED pattern queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

// Check that a condition holds in the same cycle as a trigger.
`define ASSERT_SAME(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

`endif

[src/slpq_pkg.sv]
// Types, constants and register codes of the LED pattern queue.
package slpq_pkg;

	// Field and register widths
	localparam int CFG_W      = 16;
	localparam int PHASE_W    = 16;
	localparam int CMD_W      = 4;
	localparam int PAT_W      = 2;
	localparam int NUM_PAT    = 4;
	localparam int QJOBS_W    = 5;
	localparam int CFG_IDX_W  = 8;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 8;

	// Default sizes
	localparam int DEF_QUEUE_DEPTH     = 16;
	localparam int DEF_PERIODS_PER_JOB = 50;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_PERIOD0 = 16'd1000;
	localparam logic [CFG_W-1:0] RST_DUTY0   = 16'd0;
	localparam logic [CFG_W-1:0] RST_PERIOD1 = 16'd1000;
	localparam logic [CFG_W-1:0] RST_DUTY1   = 16'd1000;
	localparam logic [CFG_W-1:0] RST_PERIOD2 = 16'd200;
	localparam logic [CFG_W-1:0] RST_DUTY2   = 16'd100;
	localparam logic [CFG_W-1:0] RST_PERIOD3 = 16'd2000;
	localparam logic [CFG_W-1:0] RST_DUTY3   = 16'd1000;

	// Pattern in force after reset
	localparam logic [CFG_W-1:0] RST_ACT_PERIOD = 16'd2000;
	localparam logic [CFG_W-1:0] RST_ACT_DUTY   = 16'd0;

	// Request kinds carried in tuser
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_PUSH = 1'b1;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_PERIOD0 = 3'd0,
		REG_DUTY0   = 3'd1,
		REG_PERIOD1 = 3'd2,
		REG_DUTY1   = 3'd3,
		REG_PERIOD2 = 3'd4,
		REG_DUTY2   = 3'd5,
		REG_PERIOD3 = 3'd6,
		REG_DUTY3   = 3'd7
	} cfg_reg_t;

endpackage

[src/slpq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module slpq_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/status_led_pattern_queue_core.sv]
// A result passes through the input stage and then the result register.
// Throughput: one item per cycle while the result stream does not stall; the next state of one item is combinational.
// The head command comes from a registered queue RAM read that is prefetched at the entry after the head.
// Reset (arst_n low, asynchronous): registers to defaults, queue empty, LED off.
// The queue RAM keeps its contents over reset; no clearing pass is run.
module status_led_pattern_queue_core
	import slpq_pkg::*;
#(
	parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH,
	parameter int PERIODS_PER_JOB = DEF_PERIODS_PER_JOB
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	// Input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // [3:0] pattern_cmd, [7:4] zero
	input  logic [0:0]            s_tuser,  // [0] req_type
	// Result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // [0] led_on, [1] showing,
	                                        // [6:2] queued_jobs, [7] push_dropped
);

	`include "assert_macros.svh"

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PER_W = (PERIODS_PER_JOB > 1) ? $clog2(PERIODS_PER_JOB) : 1;

	localparam logic [CNT_W-1:0]   CNT_FULL = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W:0]     PTR_WRAP = (PTR_W + 1)'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0]   PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [PER_W:0]     PER_DONE = (PER_W + 1)'(PERIODS_PER_JOB);

	// Configuration registers
	logic [CFG_W-1:0] period_q [NUM_PAT];
	logic [CFG_W-1:0] duty_q   [NUM_PAT];

	// Input stage
	logic             valid_s1;
	logic             req_s1;
	logic [CMD_W-1:0] cmd_s1;

	// Block state
	logic [PTR_W-1:0]   head_q;
	logic [CNT_W-1:0]   count_q;
	logic [PER_W-1:0]   periods_q;
	logic [PHASE_W-1:0] phase_q;
	logic [CFG_W-1:0]   act_period_q;
	logic [CFG_W-1:0]   act_duty_q;
	logic               led_q;
	logic [CMD_W-1:0]   head_cmd_q;
	logic               reload_q;
	logic               m_valid_q;
	logic               dropped_q;

	// Next-state values
	logic [PTR_W-1:0]   head_d;
	logic [CNT_W-1:0]   count_d;
	logic [PER_W-1:0]   periods_d;
	logic [PHASE_W-1:0] phase_d;
	logic [CFG_W-1:0]   act_period_d;
	logic [CFG_W-1:0]   act_duty_d;
	logic               led_d;
	logic [CMD_W-1:0]   head_cmd_d;
	logic               reload_d;
	logic               dropped_d;

	logic               adv;
	logic               full;
	logic               push_ok;
	logic [PTR_W:0]     tail_sum;
	logic [PTR_W-1:0]   tail;
	logic [PTR_W-1:0]   head_inc;
	logic [CMD_W-1:0]   rd_cmd;
	logic [CMD_W-1:0]   cur_cmd;
	logic [CFG_W-1:0]   sel_period;
	logic [CFG_W-1:0]   sel_duty;
	logic [CFG_W-1:0]   eff_period;
	logic [CFG_W-1:0]   eff_duty;
	logic [PHASE_W:0]   phase_inc;
	logic [PER_W:0]     per_inc;
	logic [CFG_W-1:0]   act_eff_period;

	// Handshakes: the result register frees the input stage when it is empty or taken
	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready  = !valid_s1 || adv;
	assign m_tvalid  = m_valid_q;

	// Result fields follow the state, which only changes when a new result loads
	assign m_tdata = {dropped_q, QJOBS_W'(count_q), (count_q != '0), led_q};

	// Queue pointers
	assign full     = (count_q == CNT_FULL);
	assign push_ok  = (req_s1 == REQ_PUSH) && !full;
	assign tail_sum = (PTR_W + 1)'(head_q) + (PTR_W + 1)'(count_q);
	assign tail     = (tail_sum >= PTR_WRAP) ? PTR_W'(tail_sum - PTR_WRAP) : PTR_W'(tail_sum);
	assign head_inc = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;

	// Queue storage, read one entry past the head for the job after a pop
	slpq_ram #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (adv && push_ok),
		.waddr (tail),
		.wdata (cmd_s1),
		.raddr (head_inc),
		.rdata (rd_cmd)
	);

	// Pick the head command and the pattern it selects
	assign cur_cmd = reload_q ? rd_cmd : head_cmd_q;

	always_comb begin
		sel_period = act_period_q;
		sel_duty   = act_duty_q;
		if (phase_q == '0 && cur_cmd < CMD_W'(NUM_PAT)) begin
			sel_period = period_q[cur_cmd[PAT_W-1:0]];
			sel_duty   = duty_q[cur_cmd[PAT_W-1:0]];
		end
	end

	// Clamp period and duty, step the phase
	assign eff_period = (sel_period == '0) ? CFG_W'(1) : sel_period;
	assign eff_duty   = (sel_duty > eff_period) ? eff_period : sel_duty;
	assign phase_inc  = (PHASE_W + 1)'(phase_q) + 1'b1;
	assign per_inc    = (PER_W + 1)'(periods_q) + 1'b1;

	// Next state for the item in the input stage
	always_comb begin
		head_d       = head_q;
		count_d      = count_q;
		periods_d    = periods_q;
		phase_d      = phase_q;
		act_period_d = act_period_q;
		act_duty_d   = act_duty_q;
		led_d        = led_q;
		head_cmd_d   = reload_q ? rd_cmd : head_cmd_q;
		reload_d     = 1'b0;
		dropped_d    = 1'b0;
		if (req_s1 == REQ_PUSH) begin
			if (full) begin
				dropped_d = 1'b1;
			end else begin
				if (count_q == '0) begin
					phase_d    = '0;
					periods_d  = '0;
					head_cmd_d = cmd_s1;
				end
				count_d = count_q + 1'b1;
			end
		end else if (count_q == '0) begin
			led_d = 1'b0;
		end else begin
			act_period_d = sel_period;
			act_duty_d   = sel_duty;
			led_d        = (phase_q < eff_duty);
			phase_d      = PHASE_W'(phase_inc);
			if (phase_inc >= (PHASE_W + 1)'(eff_period)) begin
				phase_d   = '0;
				periods_d = PER_W'(per_inc);
				if (per_inc >= PER_DONE) begin
					periods_d = '0;
					head_d    = head_inc;
					count_d   = count_q - 1'b1;
					reload_d  = 1'b1;
					if (count_q == CNT_W'(1)) begin
						led_d = 1'b0;
					end
				end
			end
		end
	end

	// Configuration writes; indexes past the last register are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q[0] <= RST_PERIOD0;
			duty_q[0]   <= RST_DUTY0;
			period_q[1] <= RST_PERIOD1;
			duty_q[1]   <= RST_DUTY1;
			period_q[2] <= RST_PERIOD2;
			duty_q[2]   <= RST_DUTY2;
			period_q[3] <= RST_PERIOD3;
			duty_q[3]   <= RST_DUTY3;
		end else if (cfg_valid && cfg_ready && cfg_index[CFG_IDX_W-1:3] == '0) begin
			case (cfg_reg_t'(cfg_index[2:0]))
				REG_PERIOD0: period_q[0] <= cfg_data;
				REG_DUTY0:   duty_q[0]   <= cfg_data;
				REG_PERIOD1: period_q[1] <= cfg_data;
				REG_DUTY1:   duty_q[1]   <= cfg_data;
				REG_PERIOD2: period_q[2] <= cfg_data;
				REG_DUTY2:   duty_q[2]   <= cfg_data;
				REG_PERIOD3: period_q[3] <= cfg_data;
				REG_DUTY3:   duty_q[3]   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage: capture a transfer, drop it once it moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1 <= s_tuser[0];
			cmd_s1 <= s_tdata[CMD_W-1:0];
		end
	end

	// State and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			count_q      <= '0;
			periods_q    <= '0;
			phase_q      <= '0;
			act_period_q <= RST_ACT_PERIOD;
			act_duty_q   <= RST_ACT_DUTY;
			led_q        <= 1'b0;
			head_cmd_q   <= '0;
			reload_q     <= 1'b0;
			dropped_q    <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (adv) begin
				head_q       <= head_d;
				count_q      <= count_d;
				periods_q    <= periods_d;
				phase_q      <= phase_d;
				act_period_q <= act_period_d;
				act_duty_q   <= act_duty_d;
				led_q        <= led_d;
				head_cmd_q   <= head_cmd_d;
				reload_q     <= reload_d;
				dropped_q    <= dropped_d;
				m_valid_q    <= 1'b1;
			end else begin
				// Latch the prefetched head command once after a pop
				if (reload_q) begin
					head_cmd_q <= rd_cmd;
					reload_q   <= 1'b0;
				end
				if (m_tready) begin
					m_valid_q <= 1'b0;
				end
			end
		end
	end

	// Clamped period of the pattern in force
	assign act_eff_period = (act_period_q == '0) ? CFG_W'(1) : act_period_q;

	`ASSERT_ALWAYS(a_count_bound, count_q <= CNT_FULL, "queue count above depth")
	`ASSERT_SAME(a_idle_led_off, count_q == '0, !led_q, "LED lit with an empty queue")
	`ASSERT_SAME(a_phase_bound, count_q != '0 && phase_q != '0, phase_q < act_eff_period, "phase past period")
	`ASSERT_NEXT(a_full_drop, adv && req_s1 == REQ_PUSH && full, m_valid_q && dropped_q, "full push not flagged")

endmodule
